/* sv/tcw_pkg.sv */
// Shared types, constants and helpers for the text console writer.
// No dependencies; every other file of the block imports this package.
package tcw_pkg;

    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;
    localparam int CMD_DEPTH       = 2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        MODE_CHAR  = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  char_code;
        logic [3:0]  fg_color;
        logic [3:0]  bg_color;
        logic [4:0]  read_row;
        logic [6:0]  read_col;
    } t_item;

    typedef struct packed {
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_col_out;
        logic        scrolled;
        logic [15:0] read_cell;
    } t_result;

    // One decoded operation for the screen side.
    typedef struct packed {
        logic        wr_cell;   // write cell at (prow, col)
        logic        clr_row;   // blank physical row clr_prow
        logic        fill;      // blank every cell
        logic        rd;        // read cell at (prow, col), in range
        logic [4:0]  prow;
        logic [6:0]  col;
        logic [4:0]  clr_prow;
        logic [15:0] cell_word; // written cell; bits 15:12 give the blank color
        t_result     res;       // result with read_cell still zero
    } t_cmd;

    function automatic logic [15:0] blank_cell(input logic [3:0] bg);
        return {bg, 4'h0, CH_SPACE};
    endfunction

endpackage

/* sv/text_console_writer_unit.sv */
// Text console writer, top level. A pushed word is decoded by the front end, waits in the
// command queue and is carried out by the screen engine, which registers its result word;
// a scroll adds a sweep of one row and a fill or clear a sweep of the whole screen. New words
// are taken while the queue has room; the engine runs one command at a time (pop, then write).
// Reset (synchronous, active low): cursor homes, then a clearing pass zeroes all
// SCREEN_ROWS*SCREEN_COLS cells (2000 by default) while full stays high.
module text_console_writer_unit #(
    parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  tcw_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output tcw_pkg::t_result o_result
);
    import tcw_pkg::*;

    // Front end: decode the word, move the cursor, and turn scrolling into a
    // base-row bump plus a blank sweep of one row instead of a screen copy.
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic accept;
    logic q_full, q_valid, q_pop;
    logic init_busy, out_valid;

    // Hold input words off while the queue is full or the screen is still
    // being cleared after reset.
    assign full   = q_full || init_busy;
    assign accept = push && !full;

    tcw_front #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_cmd    (front_cmd)
    );

    // Decouple decoding from the screen engine so that long sweeps do not
    // stop the front end from taking the next few words.
    tcw_cmd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // Screen engine: carry out each command in order and register its word
    // in the output slot, which parts the result side from the engine.
    tcw_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .o_valid     (out_valid),
        .i_pop       (pop),
        .o_result    (o_result)
    );

    assign empty = !out_valid;

`ifndef NO_ASSERTIONS
    // The cursor in a delivered word always lies on the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((32'(o_result.cursor_row_out) < SCREEN_ROWS) &&
                    (32'(o_result.cursor_col_out) < SCREEN_COLS)))
        else $error("cursor outside the screen");

    // A scroll always leaves the cursor on the last row.
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.scrolled) |->
            (32'(o_result.cursor_row_out) == SCREEN_ROWS - 1))
        else $error("scroll left cursor off the last row");

    // No command may reach the queue while the clearing pass is running.
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |=> (!q_valid || !$past(init_busy) || !init_busy))
        else $error("command queued during clearing pass");
`endif

endmodule

/* sv/tcw_front.sv */
// Front end: classifies each input word, tracks the cursor and the scroll base,
// and builds the screen command. Depends on tcw_pkg.
module tcw_front #(
    parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  tcw_pkg::t_item i_item,
    output tcw_pkg::t_cmd  o_cmd
);
    import tcw_pkg::*;

    logic [4:0] r_row, n_row;
    logic [6:0] r_col, n_col;
    logic [4:0] r_base, n_base;   // physical row that shows logical row 0

    logic [5:0] row_inc;
    logic [7:0] col_inc;
    logic       adv_row;
    t_cmd       cmd;

    // Map a logical row onto its physical row.
    function automatic logic [4:0] phys_row(input logic [4:0] base, input logic [4:0] row);
        logic [5:0] s;
        s = {1'b0, base} + {1'b0, row};
        if (s >= 6'(SCREEN_ROWS)) begin
            s = s - 6'(SCREEN_ROWS);
        end
        return s[4:0];
    endfunction

    assign row_inc = {1'b0, r_row} + 6'd1;
    assign col_inc = {1'b0, r_col} + 8'd1;

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_base  = r_base;
        adv_row = 1'b0;
        cmd     = '0;
        cmd.cell_word = blank_cell(i_item.bg_color);
        unique case (i_item.mode)
            MODE_CHAR: begin
                if (i_item.char_code == CH_NEWLINE) begin
                    adv_row = 1'b1;
                end else if (i_item.char_code == CH_RETURN) begin
                    n_col = '0;
                end else begin
                    cmd.wr_cell   = 1'b1;
                    cmd.prow      = phys_row(r_base, r_row);
                    cmd.col       = r_col;
                    cmd.cell_word = {i_item.bg_color, i_item.fg_color, i_item.char_code};
                    if (col_inc >= 8'(SCREEN_COLS)) begin
                        n_col   = '0;
                        adv_row = 1'b1;
                    end else begin
                        n_col = col_inc[6:0];
                    end
                end
                if (adv_row) begin
                    if (row_inc >= 6'(SCREEN_ROWS)) begin
                        // scroll: the old top row becomes the new bottom row
                        cmd.clr_row      = 1'b1;
                        cmd.clr_prow     = r_base;
                        cmd.res.scrolled = 1'b1;
                        n_base = (r_base == 5'(SCREEN_ROWS - 1)) ? '0 : r_base + 5'd1;
                    end else begin
                        n_row = row_inc[4:0];
                    end
                end
            end
            MODE_FILL: begin
                cmd.fill = 1'b1;
            end
            MODE_CLEAR: begin
                cmd.fill      = 1'b1;
                cmd.cell_word = blank_cell(4'h0);
                n_row         = '0;
                n_col         = '0;
            end
            MODE_READ: begin
                if (({1'b0, i_item.read_row} < 6'(SCREEN_ROWS)) &&
                    ({1'b0, i_item.read_col} < 8'(SCREEN_COLS))) begin
                    cmd.rd   = 1'b1;
                    cmd.prow = phys_row(r_base, i_item.read_row);
                    cmd.col  = i_item.read_col;
                end
            end
        endcase
        cmd.res.cursor_row_out = n_row;
        cmd.res.cursor_col_out = n_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_base <= '0;
        end else if (i_accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_base <= n_base;
        end
    end

    assign o_cmd = cmd;

endmodule

/* sv/tcw_cmd_queue.sv */
// Short command queue between the front end and the screen engine.
// Depends on tcw_pkg for the command type.
module tcw_cmd_queue #(
    parameter int DEPTH = tcw_pkg::CMD_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tcw_pkg::t_cmd o_data
);
    import tcw_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* sv/tcw_back.sv */
// Screen engine: owns the cell memory, runs cell writes, row and screen sweeps
// and reads, and holds the output word. Depends on tcw_pkg.
module tcw_back #(
    parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  tcw_pkg::t_cmd    i_cmd,
    output logic             o_q_pop,
    output logic             o_init_busy,
    output logic             o_valid,
    input  logic             i_pop,
    output tcw_pkg::t_result o_result
);
    import tcw_pkg::*;

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_EXEC   = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_RESULT = 5'b10000
    } t_back_state;

    t_back_state r_state;
    t_cmd        r_cmd;
    logic [AW-1:0] r_addr, r_end;
    logic [15:0]   r_rd_data;
    logic [15:0]   r_mem [CELLS];
    t_result       r_out;
    logic          r_out_valid;

    logic [AW-1:0] cmd_addr, row_base;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          slot_free, load_out, simple_cmd;
    t_result       result_word;

    assign cmd_addr = AW'(r_cmd.prow) * AW'(SCREEN_COLS) + AW'(r_cmd.col);
    assign row_base = AW'(r_cmd.clr_prow) * AW'(SCREEN_COLS);

    assign simple_cmd = !r_cmd.clr_row && !r_cmd.fill && !r_cmd.rd;
    assign slot_free  = !r_out_valid || i_pop;
    assign load_out   = slot_free &&
                        (((r_state == S_EXEC) && simple_cmd) || (r_state == S_RESULT));

    always_comb begin
        result_word           = r_cmd.res;
        result_word.read_cell = r_cmd.rd ? r_rd_data : 16'h0000;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = blank_cell(r_cmd.cell_word[15:12]);
        if (r_state == S_INIT) begin
            mem_we    = 1'b1;
            mem_wdata = 16'h0000;
        end else if (r_state == S_EXEC) begin
            mem_we    = r_cmd.wr_cell;
            mem_waddr = cmd_addr;
            mem_wdata = r_cmd.cell_word;
        end else if (r_state == S_SWEEP) begin
            mem_we = 1'b1;
        end
    end

    assign mem_re = (r_state == S_EXEC) && r_cmd.rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[cmd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= result_word;
        end
        if ((r_state == S_IDLE) && i_q_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_EXEC) begin
            r_end <= r_cmd.clr_row ? row_base + AW'(SCREEN_COLS - 1) : AW'(CELLS - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    if (r_addr == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_cmd.clr_row) begin
                        r_addr  <= row_base;
                        r_state <= S_SWEEP;
                    end else if (r_cmd.fill) begin
                        r_addr  <= '0;
                        r_state <= S_SWEEP;
                    end else if (r_cmd.rd || !slot_free) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SWEEP: begin
                    if (r_addr == r_end) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_RESULT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                    r_addr  <= '0;
                end
            endcase
        end
    end

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_init_busy = (r_state == S_INIT);
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

endmodule

/* tb/tb_top.sv */
// Self-checking bench for the text console writer: directed and random words through the
// push/full and pop/empty queue ports, checked against a cycle-free screen and cursor model.
// Depends on tcw_pkg and text_console_writer_unit.
module tb_top;
    import tcw_pkg::*;

    localparam int COLS = SCREEN_COLS_DEF;
    localparam int ROWS = SCREEN_ROWS_DEF;
    localparam int ITEM_TARGET = 1750;
    // Much of a normal run goes to full-screen fills and clears, each a sweep of all 2000
    // cells, plus the clearing pass after reset. Allow many times a normal run.
    localparam int LIMIT_CYCLES = 1500000;
    localparam int SETTLE_CYCLES = 20;
    localparam int SHOWN_ERRORS = 10;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    t_item   i_item = '0;
    logic    full;
    logic    empty;
    t_result o_result;

    // Model of the screen: cell words and cursor, updated when a word is accepted.
    logic [15:0] screen_words [ROWS*COLS];
    logic [4:0]  cur_row;
    logic [6:0]  cur_col;

    t_result expected_words[$];
    int      error_count = 0;
    int      words_sent = 0;
    bit      tx_steady = 1'b0;   // sender offers words back to back
    bit      rx_steady = 1'b0;   // receiver pops without gaps
    int      rx_hold_cycles = 0; // one long receiver stall, taken by the pop process

    text_console_writer_unit #(
        .SCREEN_COLS(COLS),
        .SCREEN_ROWS(ROWS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Screen and cursor model
    // ------------------------------------------------------------------

    // Blank every cell in the given background: space, foreground 0.
    function automatic void blank_screen(input logic [3:0] bg);
        for (int i = 0; i < ROWS*COLS; i++) begin
            screen_words[i] = {bg, 4'h0, CH_SPACE};
        end
    endfunction

    // Move all rows up by one and blank the new bottom row in bg.
    function automatic void scroll_screen(input logic [3:0] bg);
        for (int i = 0; i < (ROWS-1)*COLS; i++) begin
            screen_words[i] = screen_words[i+COLS];
        end
        for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) begin
            screen_words[i] = {bg, 4'h0, CH_SPACE};
        end
    endfunction

    function automatic t_result predict_console(input t_item it);
        t_result r;
        int      idx;
        r = '0;
        case (it.mode)
            MODE_CHAR: begin
                if (it.char_code == CH_NEWLINE) begin
                    // Keep the column. Past the bottom row, scroll and stay on the last row.
                    if (int'(cur_row) == ROWS-1) begin
                        scroll_screen(it.bg_color);
                        r.scrolled = 1'b1;
                    end else begin
                        cur_row = cur_row + 5'd1;
                    end
                end else if (it.char_code == CH_RETURN) begin
                    cur_col = '0;
                end else begin
                    idx = int'(cur_row) * COLS + int'(cur_col);
                    screen_words[idx] = {it.bg_color, it.fg_color, it.char_code};
                    if (int'(cur_col) == COLS-1) begin
                        // Wrap to the next row, scrolling when already on the last one.
                        cur_col = '0;
                        if (int'(cur_row) == ROWS-1) begin
                            scroll_screen(it.bg_color);
                            r.scrolled = 1'b1;
                        end else begin
                            cur_row = cur_row + 5'd1;
                        end
                    end else begin
                        cur_col = cur_col + 7'd1;
                    end
                end
            end
            MODE_FILL: begin
                blank_screen(it.bg_color);
            end
            MODE_CLEAR: begin
                blank_screen(4'h0);
                cur_row = '0;
                cur_col = '0;
            end
            default: begin
                // Out-of-range coordinates read as zero.
                if (int'(it.read_row) < ROWS && int'(it.read_col) < COLS) begin
                    r.read_cell = screen_words[int'(it.read_row) * COLS + int'(it.read_col)];
                end
            end
        endcase
        r.cursor_row_out = cur_row;
        r.cursor_col_out = cur_col;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender and receiver
    // ------------------------------------------------------------------

    function automatic t_item make_word(input t_mode m, input logic [7:0] ch,
                                        input logic [3:0] fg, input logic [3:0] bg,
                                        input logic [4:0] row, input logic [6:0] col);
        t_item it;
        it.mode = m;
        it.char_code = ch;
        it.fg_color = fg;
        it.bg_color = bg;
        it.read_row = row;
        it.read_col = col;
        return it;
    endfunction

    // Word with random content in every field the mode does not fix.
    function automatic t_item random_word(input t_mode m, input logic [7:0] ch);
        return make_word(m, ch, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    endfunction

    // Offer one word and hold it until accepted, then queue its expected result.
    task automatic push_word(input t_item it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        // Inputs and outputs are read right at the edge, before any update lands.
        do @(posedge i_clk); while (full);
        expected_words.push_back(predict_console(it));
        words_sent++;
    endtask

    function automatic void check_word(input t_result got);
        t_result exp;
        if (expected_words.size() == 0) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS) begin
                $display("unexpected result word %h with nothing pending", got);
            end
            return;
        end
        exp = expected_words.pop_front();
        if (got.cursor_row_out !== exp.cursor_row_out
                || got.cursor_col_out !== exp.cursor_col_out
                || got.scrolled !== exp.scrolled
                || got.read_cell !== exp.read_cell) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS) begin
                $display("mismatch: expected row %0d col %0d scrolled %0b cell %h",
                         exp.cursor_row_out, exp.cursor_col_out, exp.scrolled, exp.read_cell,
                         ", got row %0d col %0d scrolled %0b cell %h",
                         got.cursor_row_out, got.cursor_col_out, got.scrolled, got.read_cell);
            end
        end
    endfunction

    // Pop process: random gaps per word, plus the one long stall when requested.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                pop <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = rx_steady ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            check_word(o_result);
        end
    end

    // Watchdog: end the run if the cycle count runs out.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, control bytes and reads just inside and outside the screen.
    task automatic test_extremes_and_reads();
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        push_word(make_word(MODE_READ, 8'hFF, 4'hF, 4'hF, 5'(ROWS-1), 7'(COLS-1)));
        push_word(make_word(MODE_CHAR, 8'h00, 4'h0, 4'h0, 5'd31, 7'd127));
        push_word(make_word(MODE_CHAR, 8'hFF, 4'hF, 4'hF, 5'd0, 7'd0));
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd1));
        push_word(make_word(MODE_CHAR, CH_RETURN, 4'h5, 4'hA, 5'd0, 7'd0));
        push_word(make_word(MODE_CHAR, CH_NEWLINE, 4'hA, 4'h5, 5'd0, 7'd0));
        push_word(make_word(MODE_CHAR, 8'h41, 4'hF, 4'h0, 5'd0, 7'd0));
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd0));
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'(ROWS), 7'd0));
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'(COLS)));
        push_word(make_word(MODE_READ, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127));
    endtask

    // Fill keeps the cursor, clear homes it and blanks to black.
    task automatic test_fill_and_clear();
        push_word(make_word(MODE_FILL, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127));
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd12, 7'd40));
        push_word(make_word(MODE_CHAR, 8'h7E, 4'h3, 4'hC, 5'd0, 7'd0));
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd1));
        push_word(make_word(MODE_CLEAR, 8'hAA, 4'hA, 4'hA, 5'd21, 7'd85));
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd1));
        push_word(make_word(MODE_FILL, 8'h55, 4'h5, 4'h6, 5'd10, 7'd42));
        push_word(make_word(MODE_READ, 8'h00, 4'h0, 4'h0, 5'(ROWS-1), 7'(COLS-1)));
    endtask

    // Stall the receiver for a long stretch while the sender keeps pushing, so the
    // block backs up and holds full high.
    task automatic test_stall_recovery();
        tx_steady = 1'b1;
        rx_hold_cycles = 300;
        for (int i = 0; i < 40; i++) begin
            if (i % 8 == 7) begin
                push_word(random_word(MODE_READ, 8'h00));
            end else begin
                push_word(random_word(MODE_CHAR, 8'($urandom_range(32, 126))));
            end
        end
        tx_steady = 1'b0;
    endtask

    // Mostly text lines ended by return and newline, so the cursor walks down and the
    // screen scrolls; mixed with read bursts, newline runs, noise and rare fills and clears.
    task automatic test_random_text();
        int pick;
        int len;
        while (words_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            tx_steady = ($urandom_range(0, 7) == 0);
            rx_steady = ($urandom_range(0, 7) == 0);
            if (pick < 60) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(COLS-2, 2*COLS+3)
                                                  : $urandom_range(1, 24);
                repeat (len) push_word(random_word(MODE_CHAR, 8'($urandom_range(0, 255))));
                if ($urandom_range(0, 3) != 0) push_word(random_word(MODE_CHAR, CH_RETURN));
                if ($urandom_range(0, 9) != 0) push_word(random_word(MODE_CHAR, CH_NEWLINE));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        push_word(random_word(MODE_READ, 8'($urandom_range(0, 255))));
                    end else begin
                        // Aim at the cursor row now and then, where fresh text sits.
                        push_word(make_word(MODE_READ, 8'($urandom_range(0, 255)),
                                            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                            ($urandom_range(0, 1) == 0) ? cur_row
                                                : 5'($urandom_range(0, ROWS-1)),
                                            7'($urandom_range(0, COLS-1))));
                    end
                end
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 6)) push_word(random_word(MODE_CHAR, CH_NEWLINE));
            end else if (pick < 96) begin
                push_word(random_word(t_mode'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
            end else if (pick < 98) begin
                push_word(random_word(MODE_FILL, 8'($urandom_range(0, 255))));
            end else begin
                push_word(random_word(MODE_CLEAR, 8'($urandom_range(0, 255))));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Model state after reset: screen cleared, cursor home.
        for (int i = 0; i < ROWS*COLS; i++) screen_words[i] = '0;
        cur_row = '0;
        cur_col = '0;

        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The clearing pass after reset keeps full high; push_word just waits it out.
        test_extremes_and_reads();
        test_fill_and_clear();
        test_stall_recovery();
        test_random_text();
        push <= 1'b0;

        // Drain, then give any stray word time to show up.
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/tcw_pkg.sv
sv/tcw_front.sv
sv/tcw_cmd_queue.sv
sv/tcw_back.sv
sv/text_console_writer_unit.sv
tb/tb_top.sv
